@@ hdl/skt_pkg.sv @@
// shared types, widths and codes for the sorted key table
`default_nettype none

package skt_pkg;

  // payload field widths
  localparam int unsigned KEY_W    = 27;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned INDEX_W  = 5;
  localparam int unsigned COUNT_W  = 6;

  // default number of table slots
  localparam int unsigned CAPACITY_DEF = 32;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  // operation codes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  // read address selection, relative to the slot pointer
  typedef enum logic [1:0] {
    RD_PTR    = 2'd0,
    RD_PTR_M1 = 2'd1,
    RD_PTR_M2 = 2'd2,
    RD_PTR_P1 = 2'd3
  } rd_sel_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_INS_CMP,
    S_INS_PUT,
    S_SRCH_CMP,
    S_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_key;
    logic    ptr_dec;
    logic    ptr_inc;
    logic    res_set;
    status_t res_status;
    logic    res_from_ptr;
    logic    emit;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic full;
    logic count_zero;
    logic ptr_one;
    logic ptr_last;
    logic ge;
    logic eq;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/skt_ifs.sv @@
// valid/ready channel interfaces for the sorted key table
`default_nettype none

interface skt_in_if import skt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [KEY_W-1:0] key;

  modport source (output valid, output op, output key, input ready);
  modport sink   (input valid, input op, input key, output ready);
endinterface

interface skt_out_if import skt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [INDEX_W-1:0]  index;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output index, output count, input ready);
  modport sink   (input valid, input status, input index, input count, output ready);
endinterface

`default_nettype wire

@@ hdl/sorted_key_table_core.sv @@
// Sorted key table: keeps up to CAPACITY 27-bit keys in ascending order in a
// single-port-write, single-registered-read memory. An insert transaction walks
// down from the top entry, moving each entry not less than the new key up one slot,
// then writes the key below them, so a new key lands before equal ones; a full table
// answers status full and changes nothing. A search transaction walks up from slot 0
// and reports the lowest slot with an equal key, or not found. Each transaction gives
// one result carrying the entry count afterwards. The memory visits one slot per
// cycle, so the time from acceptance to result grows with the number of stored keys;
// a new transaction is taken once the previous result sits in the output register.
// No clearing pass is needed after reset.
`default_nettype none

module sorted_key_table_core import skt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  skt_in_if.sink     in_ch,
  skt_out_if.source  out_ch
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  // sequencing
  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and compare
  skt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_op  (in_ch.op),
    .in_key (in_ch.key),
    .cmd    (cmd),
    .sts    (sts),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

@@ hdl/skt_ctrl.sv @@
// controller state machine for the sorted key table
`default_nettype none

module skt_ctrl import skt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        if (sts.op == OP_INSERT) begin
          if (sts.full)            state_nxt = S_EMIT;
          else if (sts.count_zero) state_nxt = S_INS_PUT;
          else                     state_nxt = S_INS_CMP;
        end else begin
          if (sts.count_zero) state_nxt = S_EMIT;
          else                state_nxt = S_SRCH_CMP;
        end
      end
      S_INS_CMP: begin
        if (!sts.ge)          state_nxt = S_EMIT;
        else if (sts.ptr_one) state_nxt = S_INS_PUT;
      end
      S_INS_PUT: begin
        state_nxt = S_EMIT;
      end
      S_SRCH_CMP: begin
        if (sts.eq || sts.ptr_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd          = '0;
    cmd.rd_sel   = RD_PTR;
    cmd.res_status = ST_OK;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START: begin
        if (sts.op == OP_INSERT) begin
          if (sts.full) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_FULL;
          end else if (!sts.count_zero) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR_M1;
          end
        end else begin
          if (sts.count_zero) begin
            cmd.res_set    = 1'b1;
            cmd.res_status = ST_MISSING;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR;
          end
        end
      end
      S_INS_CMP: begin
        if (sts.ge) begin
          // move the entry up one slot and look at the one below
          cmd.wr_shift = 1'b1;
          cmd.ptr_dec  = 1'b1;
          if (!sts.ptr_one) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_PTR_M2;
          end
        end else begin
          cmd.wr_key       = 1'b1;
          cmd.res_set      = 1'b1;
          cmd.res_status   = ST_OK;
          cmd.res_from_ptr = 1'b1;
        end
      end
      S_INS_PUT: begin
        cmd.wr_key       = 1'b1;
        cmd.res_set      = 1'b1;
        cmd.res_status   = ST_OK;
        cmd.res_from_ptr = 1'b1;
      end
      S_SRCH_CMP: begin
        if (sts.eq) begin
          cmd.res_set      = 1'b1;
          cmd.res_status   = ST_OK;
          cmd.res_from_ptr = 1'b1;
        end else if (sts.ptr_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_MISSING;
        end else begin
          cmd.ptr_inc = 1'b1;
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = RD_PTR_P1;
        end
      end
      S_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/skt_dp.sv @@
// datapath of the sorted key table: key memory, slot pointer, count and result registers
`default_nettype none

module skt_dp import skt_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_op,
  input  wire logic [KEY_W-1:0] in_key,
  input  wire cmd_t             cmd,
  output sts_t                  sts,
  skt_out_if.source             out_ch
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [KEY_W-1:0] mem [CAPACITY];

  logic [KEY_W-1:0] key_r;
  op_t              op_r;
  logic [KEY_W-1:0] rdata_r;
  logic [CW-1:0]    ptr_r;
  logic [CW-1:0]    count_r;
  status_t          res_status_r;
  logic [CW-1:0]    res_index_r;
  logic             out_valid_r;
  status_t          out_status_r;
  logic [INDEX_W-1:0] out_index_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [CW-1:0]    rd_ptr;
  logic [AW-1:0]    rd_addr;
  logic [CW:0]      ptr_p1;
  logic [CW+INDEX_W-1:0] index_ext;
  logic [CW+COUNT_W-1:0] count_ext;

  // read address relative to the pointer
  always_comb begin
    case (cmd.rd_sel)
      RD_PTR:    rd_ptr = ptr_r;
      RD_PTR_M1: rd_ptr = ptr_r - CW'(1);
      RD_PTR_M2: rd_ptr = ptr_r - CW'(2);
      RD_PTR_P1: rd_ptr = ptr_r + CW'(1);
      default:   rd_ptr = ptr_r;
    endcase
  end
  assign rd_addr = rd_ptr[AW-1:0];

  // key memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    if (cmd.wr_shift) begin
      mem[ptr_r[AW-1:0]] <= rdata_r;
    end else if (cmd.wr_key) begin
      mem[ptr_r[AW-1:0]] <= key_r;
    end
  end

  // captured transaction and slot pointer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= in_key;
      op_r  <= op_t'(in_op);
      ptr_r <= (op_t'(in_op) == OP_SEARCH) ? '0 : count_r;
    end else if (cmd.ptr_dec) begin
      ptr_r <= ptr_r - CW'(1);
    end else if (cmd.ptr_inc) begin
      ptr_r <= ptr_r + CW'(1);
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.wr_key) begin
      count_r <= count_r + CW'(1);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status_r <= cmd.res_status;
      res_index_r  <= cmd.res_from_ptr ? ptr_r : '0;
    end
  end

  // output register
  assign index_ext = {{INDEX_W{1'b0}}, res_index_r};
  assign count_ext = {{COUNT_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_index_r  <= index_ext[INDEX_W-1:0];
      out_count_r  <= count_ext[COUNT_W-1:0];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.index  = out_index_r;
  assign out_ch.count  = out_count_r;

  // status towards the controller
  assign ptr_p1 = {1'b0, ptr_r} + (CW+1)'(1);

  always_comb begin
    sts.op         = op_r;
    sts.full       = count_r >= CW'(CAPACITY);
    sts.count_zero = count_r == '0;
    sts.ptr_one    = ptr_r == CW'(1);
    sts.ptr_last   = ptr_p1 == {1'b0, count_r};
    sts.ge         = rdata_r >= key_r;
    sts.eq         = rdata_r == key_r;
    sts.out_free   = !out_valid_r || out_ch.ready;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (count_r != $past(count_r)) |-> count_r == $past(count_r) + CW'(1))
    else $error("entry count moved by other than one");

  a_shift_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> (ptr_r != '0) && (ptr_r <= count_r) && (ptr_r < CW'(CAPACITY)))
    else $error("shift writes outside the occupied range");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ch.ready))
    else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
